// ===== sv/tiny_register_machine_execute_macros.svh =====
// Assertion macros shared by the tiny register machine execute block.
// Users must have i_clk and i_rst_n in scope.
`ifndef TINY_REGISTER_MACHINE_EXECUTE_MACROS_SVH
`define TINY_REGISTER_MACHINE_EXECUTE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define TRME_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("trme: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define TRME_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("trme: next-cycle check failed");

`endif

// ===== sv/trme_pkg.sv =====
// Types and constants of the tiny register machine execute block.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package trme_pkg;

    localparam int DATA_W = 32;
    localparam int PC_W   = 16;
    localparam int LEN_W  = 16;
    localparam int IDX_W  = 4;
    localparam int OP_W   = 4;
    localparam int OFF_W  = 16;

    // Opcodes
    localparam logic [OP_W-1:0] OP_NOP     = 4'd0;
    localparam logic [OP_W-1:0] OP_MOV_IMM = 4'd1;
    localparam logic [OP_W-1:0] OP_MOV_REG = 4'd2;
    localparam logic [OP_W-1:0] OP_ADD_IMM = 4'd3;
    localparam logic [OP_W-1:0] OP_ADD_REG = 4'd4;
    localparam logic [OP_W-1:0] OP_CMP_IMM = 4'd5;
    localparam logic [OP_W-1:0] OP_CMP_REG = 4'd6;
    localparam logic [OP_W-1:0] OP_BEQ     = 4'd7;
    localparam logic [OP_W-1:0] OP_BNE     = 4'd8;

    // Instruction classes produced by the front end
    typedef logic [2:0] t_kind;
    localparam t_kind K_NOP = 3'd0;
    localparam t_kind K_MOV = 3'd1;
    localparam t_kind K_ADD = 3'd2;
    localparam t_kind K_CMP = 3'd3;
    localparam t_kind K_BR  = 3'd4;
    localparam t_kind K_BAD = 3'd5;

    typedef struct packed {
        logic        [OP_W-1:0]   operation;
        logic        [IDX_W-1:0]  dest_reg;
        logic        [IDX_W-1:0]  src1_reg;
        logic        [IDX_W-1:0]  src2_reg;
        logic signed [DATA_W-1:0] immediate;
        logic signed [OFF_W-1:0]  branch_offset;
    } t_item;

    typedef struct packed {
        logic        [PC_W-1:0]   next_pc;
        logic                     write_enable;
        logic        [IDX_W-1:0]  write_index;
        logic signed [DATA_W-1:0] write_value;
        logic                     zero_flag;
        logic                     negative_flag;
        logic                     finished;
        logic                     invalid_op;
    } t_result;

    // Classified instruction passed from front to back
    typedef struct packed {
        t_kind               kind;
        logic                use_imm;
        logic                br_eq;
        logic [IDX_W-1:0]    dest;
        logic [IDX_W-1:0]    addr_a;
        logic [IDX_W-1:0]    addr_b;
        logic [DATA_W-1:0]   imm;
        logic [OFF_W-1:0]    off;
    } t_uop;

endpackage

// ===== sv/tiny_register_machine_execute.sv =====
// Execute stage of a tiny register machine: one decoded instruction per request.
// Instruction channel: push/full; a request is taken at a clock edge with push high
//   and full low. Result channel: empty/pop; the oldest result sits on o_result while
//   empty is low and is taken at an edge with pop high and empty low.
// Configuration: i_cfg_valid/o_cfg_ready writes program_length; ready is always high.
//   Write it only while no instruction is in flight.
// A result passes the instruction queue, the execute register and the result queue.
// Throughput: one instruction per cycle while the result queue has room, set by the
//   single execute step that reads two register file ports, updates pc and flags and
//   writes back; a write is bypassed to the very next instruction.
// Each instruction gives exactly one result. After reset the register file,
//   pc, flags, halt state and program_length are zero, so results show finished
//   until program_length is written.
// A stalled receiver fills the two-entry result queue, then the execute step holds,
//   then the two-entry instruction queue fills and full rises.
// Depends on trme_pkg, trme_front, trme_back and trme_outq.
`timescale 1ns / 1ps

module tiny_register_machine_execute #(
    parameter int REG_COUNT = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  trme_pkg::t_item            i_item,
    output logic                       empty,
    input  logic                       pop,
    output trme_pkg::t_result          o_result,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [trme_pkg::LEN_W-1:0] i_cfg_data
);
    import trme_pkg::*;

    logic    q_valid;
    logic    q_take;
    t_uop    q_uop;
    logic    res_push;
    logic    res_full;
    t_result res;

    assign o_cfg_ready = 1'b1;

    // Accept and classify instructions
    trme_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_item  (i_item),
        .o_valid (q_valid),
        .i_take  (q_take),
        .o_uop   (q_uop)
    );

    // Execute against the register file
    trme_back #(
        .REG_COUNT (REG_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_q_take    (q_take),
        .i_uop       (q_uop),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_out_push  (res_push),
        .i_out_full  (res_full),
        .o_result    (res)
    );

    // Buffer results for the receiver
    trme_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .o_full  (res_full),
        .i_res   (res),
        .o_empty (empty),
        .i_pop   (pop),
        .o_res   (o_result)
    );

endmodule

// ===== sv/trme_front.sv =====
// Front end: accepts instructions, classifies them and queues them for the back end.
// Depends on trme_pkg.
`timescale 1ns / 1ps

module trme_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_full,
    input  trme_pkg::t_item i_item,
    output logic            o_valid,
    input  logic            i_take,
    output trme_pkg::t_uop  o_uop
);
    import trme_pkg::*;

    t_uop       dec;
    t_uop       r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       push_ok;
    logic       pop_ok;
    logic       is_cmp;

    // Classify the incoming instruction and pick its operand registers
    always_comb begin
        dec.use_imm = 1'b0;
        dec.br_eq   = 1'b0;
        is_cmp      = 1'b0;
        unique case (i_item.operation)
            OP_NOP: begin
                dec.kind = K_NOP;
            end
            OP_MOV_IMM: begin
                dec.kind    = K_MOV;
                dec.use_imm = 1'b1;
            end
            OP_MOV_REG: begin
                dec.kind = K_MOV;
            end
            OP_ADD_IMM: begin
                dec.kind    = K_ADD;
                dec.use_imm = 1'b1;
            end
            OP_ADD_REG: begin
                dec.kind = K_ADD;
            end
            OP_CMP_IMM: begin
                dec.kind    = K_CMP;
                dec.use_imm = 1'b1;
                is_cmp      = 1'b1;
            end
            OP_CMP_REG: begin
                dec.kind = K_CMP;
                is_cmp   = 1'b1;
            end
            OP_BEQ: begin
                dec.kind  = K_BR;
                dec.br_eq = 1'b1;
            end
            OP_BNE: begin
                dec.kind = K_BR;
            end
            default: begin
                dec.kind = K_BAD;
            end
        endcase
        dec.dest   = i_item.dest_reg;
        dec.addr_a = is_cmp ? i_item.dest_reg : i_item.src1_reg;
        dec.addr_b = is_cmp ? i_item.src1_reg : i_item.src2_reg;
        dec.imm    = i_item.immediate;
        dec.off    = i_item.branch_offset;
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_uop   = r_slot[r_rp];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_take && o_valid;

    // Track queue occupancy
    always_comb begin
        unique case ({push_ok, pop_ok})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_ok) begin
                r_wp <= ~r_wp;
            end
            if (pop_ok) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= n_cnt;
        end
    end

    // Store the classified request
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_slot[r_wp] <= dec;
        end
    end

endmodule

// ===== sv/trme_back.sv =====
// Back end: register file, flags, program counter and the execute step.
// Depends on trme_pkg and the assertion macros.
`timescale 1ns / 1ps
`include "tiny_register_machine_execute_macros.svh"

module trme_back #(
    parameter int REG_COUNT = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    output logic                          o_q_take,
    input  trme_pkg::t_uop                i_uop,
    input  logic                          i_cfg_valid,
    input  logic [trme_pkg::LEN_W-1:0]    i_cfg_data,
    output logic                          o_out_push,
    input  logic                          i_out_full,
    output trme_pkg::t_result             o_result
);
    import trme_pkg::*;

    localparam int AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int EW = (AW > IDX_W) ? AW : IDX_W;
    localparam logic [PC_W-1:0] PC_MAX = '1;

    function automatic logic [AW-1:0] f_addr(input logic [IDX_W-1:0] idx);
        logic [EW-1:0] ext;
        ext = EW'(idx);
        return ext[AW-1:0];
    endfunction

    function automatic logic f_inr(input logic [IDX_W-1:0] idx);
        return int'(idx) < REG_COUNT;
    endfunction

    // Register file storage
    logic [DATA_W-1:0]    r_mem [REG_COUNT];
    logic [REG_COUNT-1:0] r_vld;

    // Execute stage
    logic              r_e_valid;
    t_uop              r_e;
    logic [DATA_W-1:0] r_rd_a;
    logic [DATA_W-1:0] r_rd_b;
    logic              r_a_ok;
    logic              r_b_ok;
    logic              r_a_fwd;
    logic              r_b_fwd;
    logic [DATA_W-1:0] r_fwd_val;

    // Architectural state
    logic [PC_W-1:0]  r_pc;
    logic             r_z;
    logic             r_n;
    logic             r_halt;
    logic [LEN_W-1:0] r_len;

    logic [PC_W-1:0]   n_pc;
    logic              n_z;
    logic              n_n;
    logic              n_halt;
    logic              fire;
    logic              load;
    logic              active;
    logic              wen;
    logic [DATA_W-1:0] wval;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     ra;
    logic [AW-1:0]     rb;
    logic [DATA_W-1:0] opa;
    logic [DATA_W-1:0] opb;
    logic [DATA_W-1:0] op2;
    logic [DATA_W-1:0] sum;
    logic [DATA_W-1:0] dif;
    logic [PC_W-1:0]   seq;
    logic [PC_W+1:0]   tgt;
    logic              take;

    assign fire       = r_e_valid && !i_out_full;
    assign load       = i_q_valid && (!r_e_valid || fire);
    assign o_q_take   = load;
    assign o_out_push = fire;
    assign ra         = f_addr(i_uop.addr_a);
    assign rb         = f_addr(i_uop.addr_b);

    // Operands: bypass the write done at the read edge, zero for unwritten entries
    assign opa = r_a_fwd ? r_fwd_val : (r_a_ok ? r_rd_a : '0);
    assign opb = r_b_fwd ? r_fwd_val : (r_b_ok ? r_rd_b : '0);
    assign op2 = r_e.use_imm ? r_e.imm : opb;
    assign sum = opa + op2;
    assign dif = opa - op2;
    assign seq = (r_pc == PC_MAX) ? PC_MAX : r_pc + PC_W'(1);
    assign tgt = {2'b00, r_pc} + {{2{r_e.off[OFF_W-1]}}, r_e.off};
    assign take = r_e.br_eq ? r_z : !r_z;
    assign active = !r_halt && (r_pc < r_len);

    // Execute one instruction
    always_comb begin
        n_pc   = r_pc;
        n_z    = r_z;
        n_n    = r_n;
        n_halt = r_halt;
        wen    = 1'b0;
        wval   = '0;
        if (active) begin
            unique case (r_e.kind)
                K_NOP: begin
                    n_pc = seq;
                end
                K_MOV: begin
                    wen  = 1'b1;
                    wval = r_e.use_imm ? r_e.imm : opa;
                    n_pc = seq;
                end
                K_ADD: begin
                    wen  = 1'b1;
                    wval = sum;
                    n_pc = seq;
                end
                K_CMP: begin
                    n_z  = (dif == '0);
                    n_n  = dif[DATA_W-1];
                    n_pc = seq;
                end
                K_BR: begin
                    if (!take) begin
                        n_pc = seq;
                    end else if (tgt[PC_W+1]) begin
                        n_halt = 1'b1;
                    end else if (tgt[PC_W]) begin
                        n_pc = PC_MAX;
                    end else begin
                        n_pc = tgt[PC_W-1:0];
                    end
                end
                default: begin
                    n_halt = 1'b1;
                end
            endcase
        end
        // Drop writes to registers that do not exist
        if (!f_inr(r_e.dest)) begin
            wen = 1'b0;
        end
    end

    assign wr_en   = fire && wen;
    assign wr_addr = f_addr(r_e.dest);

    // Build the result
    always_comb begin
        o_result.next_pc       = n_pc;
        o_result.write_enable  = wen;
        o_result.write_index   = wen ? r_e.dest : '0;
        o_result.write_value   = wen ? wval : '0;
        o_result.zero_flag     = n_z;
        o_result.negative_flag = n_n;
        o_result.finished      = (n_pc >= r_len);
        o_result.invalid_op    = n_halt;
    end

    // Register file write and registered reads
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wval;
        end
        if (load) begin
            r_rd_a <= r_mem[ra];
            r_rd_b <= r_mem[rb];
        end
    end

    // Capture the next request and its operand status
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_e       <= i_uop;
            r_a_ok    <= f_inr(i_uop.addr_a) && r_vld[ra];
            r_b_ok    <= f_inr(i_uop.addr_b) && r_vld[rb];
            r_a_fwd   <= wr_en && f_inr(i_uop.addr_a) && (wr_addr == ra);
            r_b_fwd   <= wr_en && f_inr(i_uop.addr_b) && (wr_addr == rb);
            r_fwd_val <= wval;
        end
    end

    // Control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
            r_vld     <= '0;
            r_pc      <= '0;
            r_z       <= 1'b0;
            r_n       <= 1'b0;
            r_halt    <= 1'b0;
            r_len     <= '0;
        end else begin
            if (load) begin
                r_e_valid <= 1'b1;
            end else if (fire) begin
                r_e_valid <= 1'b0;
            end
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            if (fire) begin
                r_pc   <= n_pc;
                r_z    <= n_z;
                r_n    <= n_n;
                r_halt <= n_halt;
            end
            if (i_cfg_valid) begin
                r_len <= i_cfg_data;
            end
        end
    end

    `TRME_ASSERT_NEXT(a_halt_sticky, i_rst_n && r_halt, r_halt)
    `TRME_ASSERT_NOW(a_write_needs_fire, wr_en, fire && f_inr(r_e.dest))
    `TRME_ASSERT_NEXT(a_pc_holds_when_idle, i_rst_n && !fire, $stable(r_pc))
    `TRME_ASSERT_NOW(a_flags_only_on_cmp, fire && r_e.kind != K_CMP, n_z == r_z && n_n == r_n)

endmodule

// ===== sv/trme_outq.sv =====
// Result queue: two-entry buffer between the execute step and the result port.
// Depends on trme_pkg.
`timescale 1ns / 1ps

module trme_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  trme_pkg::t_result i_res,
    output logic              o_empty,
    input  logic              i_pop,
    output trme_pkg::t_result o_res
);
    import trme_pkg::*;

    t_result    r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       push_ok;
    logic       pop_ok;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_res   = r_slot[r_rp];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    // Track occupancy
    always_comb begin
        unique case ({push_ok, pop_ok})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_ok) begin
                r_wp <= ~r_wp;
            end
            if (pop_ok) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= n_cnt;
        end
    end

    // Hold results until taken
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_slot[r_wp] <= i_res;
        end
    end

endmodule
